// File: rtl/core/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

  // Hue sectors, 60 degrees each
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  localparam int SECTOR_DEG  = 60;
  localparam int NUM_SECTORS = 6;
  // floor(hue * HUE_RECIP / 2^16) == hue / 60 for every 9-bit hue
  localparam int HUE_RECIP   = 1093;
  localparam int HUE_SHIFT   = 16;

  localparam int FULL        = 255;
  localparam int HALF_P      = 127;       // round-half-up bias for /255
  localparam int P_RECIP     = 257;       // y*257 >> 16 is floor(y/255) or one less
  localparam int P_SHIFT     = 16;

  localparam int DEN_Q       = 15300;     // 60 * 255
  localparam int HALF_Q      = 7650;
  localparam int Q_RECIP     = 280716;    // floor(2^32 / 15300)
  localparam int Q_SHIFT     = 32;

  // After stage 1: sector and remainder
  typedef struct packed {
    sector_t    sector;
    logic [5:0] rem;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] alpha;
  } sect_t;

  // After stage 2: raw products
  typedef struct packed {
    sector_t     sector;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [13:0] sr;        // s*r
    logic [13:0] st;        // s*(60-r)
    logic [15:0] pn;        // v*(255-s)
  } mid_t;

  // After stage 3: biased numerators
  typedef struct packed {
    sector_t     sector;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [21:0] mq;
    logic [21:0] mt;
    logic [15:0] mp;
  } prod_t;

  function automatic logic [7:0] clamp8(input logic [8:0] x);
    logic [7:0] res;
    res = (x > 9'(FULL)) ? 8'(FULL) : x[7:0];
    return res;
  endfunction

endpackage

// File: rtl/core/hsv_to_rgb_pixel_top.sv
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------
// input    in_valid / in_stall  hue, saturation, brightness, alpha_in
// output   out_valid / out_stall color_out (ARGB, alpha in 31:24)
//
// Five register stages: sector split, products, scale and bias,
// reciprocal estimate, correct and pack. One pixel per clock while in_stall is low.
// rst is synchronous and clears only the stage valid bits.
// A stall holds a full stage; bubbles ahead of it still close up, so
// in_stall rises only when all five stages hold a pixel.

module hsv_to_rgb_pixel_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [8:0]  hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  input  logic [7:0]  alpha_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] color_out
);
  import hsvrgb_pkg::*;

  logic  in_ready;
  logic  sect_valid;
  logic  sect_ready;
  sect_t sect_data;
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod_data;

  assign in_stall = !in_ready;

  hsvrgb_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .alpha_in   (alpha_in),
    .out_valid  (sect_valid),
    .out_ready  (sect_ready),
    .out_data   (sect_data)
  );

  hsvrgb_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sect_valid),
    .in_ready  (sect_ready),
    .in_data   (sect_data),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  hsvrgb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .color_out (color_out)
  );

endmodule

// File: rtl/core/hsvrgb_sector.sv
`timescale 1ns / 1ps

module hsvrgb_sector (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [8:0]          hue,
  input  logic [7:0]          saturation,
  input  logic [7:0]          brightness,
  input  logic [7:0]          alpha_in,
  output logic                out_valid,
  input  logic                out_ready,
  output hsvrgb_pkg::sect_t   out_data
);
  import hsvrgb_pkg::*;

  logic [19:0] hue_scaled;
  logic [3:0]  hue_quot;
  logic [5:0]  hue_rem;
  logic [2:0]  sec;
  sect_t       data_next;

  // reciprocal multiply; exact over the whole 9-bit range
  assign hue_scaled = 20'(hue) * 20'(HUE_RECIP);
  assign hue_quot   = hue_scaled[HUE_SHIFT +: 4];
  assign hue_rem    = 6'(hue - 9'(hue_quot) * 9'(SECTOR_DEG));
  // hues past 359 wrap into the first sectors
  assign sec        = (hue_quot >= 4'(NUM_SECTORS)) ? 3'(hue_quot - 4'(NUM_SECTORS))
                                                     : hue_quot[2:0];

  always_comb begin
    data_next.sector = sector_t'(sec);
    data_next.rem    = hue_rem;
    data_next.sat    = saturation;
    data_next.val    = brightness;
    data_next.alpha  = alpha_in;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/core/hsvrgb_prod.sv
`timescale 1ns / 1ps

module hsvrgb_prod (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsvrgb_pkg::sect_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsvrgb_pkg::prod_t   out_data
);
  import hsvrgb_pkg::*;

  logic  mid_valid;
  logic  mid_ready;
  mid_t  mid;
  mid_t  mid_next;
  prod_t data_next;
  logic [5:0] rem_comp;

  // stage 2: the three products
  assign rem_comp = 6'(SECTOR_DEG) - in_data.rem;

  always_comb begin
    mid_next.sector = in_data.sector;
    mid_next.val    = in_data.val;
    mid_next.alpha  = in_data.alpha;
    mid_next.sr     = 14'(in_data.sat) * 14'(in_data.rem);
    mid_next.st     = 14'(in_data.sat) * 14'(rem_comp);
    mid_next.pn     = 16'(in_data.val) * 16'(8'(FULL) - in_data.sat);
  end

  assign in_ready = !mid_valid || mid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_ready) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mid <= mid_next;
    end
  end

  // stage 3: scale by v and add the rounding bias
  always_comb begin
    data_next.sector = mid.sector;
    data_next.val    = mid.val;
    data_next.alpha  = mid.alpha;
    data_next.mq     = 22'(mid.val) * 22'(14'(DEN_Q) - mid.sr) + 22'(HALF_Q);
    data_next.mt     = 22'(mid.val) * 22'(14'(DEN_Q) - mid.st) + 22'(HALF_Q);
    data_next.mp     = mid.pn + 16'(HALF_P);
  end

  assign mid_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_ready) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && mid_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/core/hsvrgb_div.sv
`timescale 1ns / 1ps

module hsvrgb_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsvrgb_pkg::prod_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         color_out
);
  import hsvrgb_pkg::*;

  localparam int QW = 22 + 19;
  localparam int PW = 16 + 9;

  logic        est_valid;
  logic        est_ready;
  prod_t       est_data;
  logic [7:0]  q_est;
  logic [7:0]  t_est;
  logic [7:0]  p_est;
  logic [QW-1:0] q_prod;
  logic [QW-1:0] t_prod;
  logic [PW-1:0] p_prod;

  logic [21:0] q_left;
  logic [21:0] t_left;
  logic [15:0] p_left;
  logic [7:0]  q_ch;
  logic [7:0]  t_ch;
  logic [7:0]  p_ch;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] color_next;

  // stage 4: reciprocal estimates, each exact or one low
  assign q_prod = QW'(in_data.mq) * QW'(Q_RECIP);
  assign t_prod = QW'(in_data.mt) * QW'(Q_RECIP);
  assign p_prod = PW'(in_data.mp) * PW'(P_RECIP);

  assign in_ready = !est_valid || est_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      est_valid <= 1'b0;
    end else if (in_ready) begin
      est_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      est_data <= in_data;
      q_est    <= q_prod[Q_SHIFT +: 8];
      t_est    <= t_prod[Q_SHIFT +: 8];
      p_est    <= p_prod[P_SHIFT +: 8];
    end
  end

  // stage 5: one correction step, channel order, pack
  assign q_left = est_data.mq - 22'(q_est) * 22'(DEN_Q);
  assign t_left = est_data.mt - 22'(t_est) * 22'(DEN_Q);
  assign p_left = est_data.mp - 16'(p_est) * 16'(FULL);

  assign q_ch = clamp8(9'(q_est) + 9'(q_left >= 22'(DEN_Q)));
  assign t_ch = clamp8(9'(t_est) + 9'(t_left >= 22'(DEN_Q)));
  assign p_ch = clamp8(9'(p_est) + 9'(p_left >= 16'(FULL)));

  always_comb begin
    case (est_data.sector)
      SEC_RED_YEL: begin red = est_data.val; green = t_ch;         blue = p_ch;         end
      SEC_YEL_GRN: begin red = q_ch;         green = est_data.val; blue = p_ch;         end
      SEC_GRN_CYN: begin red = p_ch;         green = est_data.val; blue = t_ch;         end
      SEC_CYN_BLU: begin red = p_ch;         green = q_ch;         blue = est_data.val; end
      SEC_BLU_MAG: begin red = t_ch;         green = p_ch;         blue = est_data.val; end
      default:     begin red = est_data.val; green = p_ch;         blue = q_ch;         end
    endcase
  end

  assign color_next = {est_data.alpha, red, green, blue};

  assign est_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (est_ready) begin
      out_valid <= est_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (est_ready && est_valid) begin
      color_out <= color_next;
    end
  end

endmodule

// File: rtl/core/hsvrgb_chk.sv
`timescale 1ns / 1ps

module hsvrgb_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [8:0]  hue,
  input logic [7:0]  saturation,
  input logic [7:0]  brightness,
  input logic [7:0]  alpha_in,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] color_out
);

  localparam logic [2:0] DEPTH = 3'd5;

  logic       in_xfer;
  logic       out_xfer;
  logic [2:0] inflight;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 3'd0;
    end else begin
      inflight <= inflight + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(color_out))
    else $error("result changed while stalled");

  // no result without a pixel inside
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 3'd0)
    else $error("result with no pixel in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= DEPTH)
    else $error("more pixels in flight than stages");

  // input stalls only when every stage is full and the output is stalled
  a_no_early_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_stall && inflight == DEPTH)
    else $error("input stalled with room in the pipeline");

endmodule

bind hsv_to_rgb_pixel_top hsvrgb_chk u_chk (.*);

// File: verif/hsv_pixel_checker.sv
`timescale 1ns / 1ps

module hsv_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [8:0]  hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  input  logic [7:0]  alpha_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] color_out,
  output int          fail_cnt,
  output int          pending_cnt
);

  import hsvrgb_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [31:0] argb_q[$];
  int          fails = 0;

  // nearest integer, halves go up
  function automatic int unsigned div_round(input int unsigned num, input int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic [7:0] sat8(input int unsigned x);
    return (x > FULL) ? 8'(FULL) : 8'(x);
  endfunction

  function automatic logic [31:0] argb_from_hsv(input logic [8:0] h, input logic [7:0] s,
                                                input logic [7:0] v, input logic [7:0] a);
    int unsigned hv, sv, vv, rem, pv, qv, tv, rd, gr, bl;
    sector_t     sec;
    hv  = h;
    sv  = s;
    vv  = v;
    // hues above 359 wrap into the low sectors
    sec = sector_t'((hv / SECTOR_DEG) % NUM_SECTORS);
    rem = hv % SECTOR_DEG;
    pv  = div_round(vv * (FULL - sv), FULL);
    qv  = div_round(vv * (DEN_Q - sv * rem), DEN_Q);
    tv  = div_round(vv * (DEN_Q - sv * (SECTOR_DEG - rem)), DEN_Q);
    case (sec)
      SEC_RED_YEL: begin rd = vv; gr = tv; bl = pv; end
      SEC_YEL_GRN: begin rd = qv; gr = vv; bl = pv; end
      SEC_GRN_CYN: begin rd = pv; gr = vv; bl = tv; end
      SEC_CYN_BLU: begin rd = pv; gr = qv; bl = vv; end
      SEC_BLU_MAG: begin rd = tv; gr = pv; bl = vv; end
      default:     begin rd = vv; gr = pv; bl = qv; end
    endcase
    return {a, sat8(rd), sat8(gr), sat8(bl)};
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      argb_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (argb_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("[%0t] unexpected pixel %08h, nothing pending", $realtime, color_out);
        end else begin
          want = argb_q.pop_front();
          if (color_out !== want) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("[%0t] pixel mismatch: expected %08h got %08h", $realtime, want,
                       color_out);
          end
        end
      end
      if (in_valid && !in_stall)
        argb_q = {argb_q, argb_from_hsv(hue, saturation, brightness, alpha_in)};
    end
    fail_cnt    <= fails;
    pending_cnt <= argb_q.size();
  end

endmodule

// File: verif/tb_hsv_to_rgb_pixel_top.sv
`timescale 1ns / 1ps

module tb_hsv_to_rgb_pixel_top;

  localparam int RANDOM_PIXELS = 1850;
  localparam int PHASE_LEN     = 250;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 1000000;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [8:0]  hue        = '0;
  logic [7:0]  saturation = '0;
  logic [7:0]  brightness = '0;
  logic [7:0]  alpha_in   = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] color_out;

  int fail_cnt;
  int pending_cnt;
  int cycle_cnt    = 0;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  hsv_to_rgb_pixel_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .alpha_in   (alpha_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .color_out  (color_out)
  );

  hsv_pixel_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .hue         (hue),
    .saturation  (saturation),
    .brightness  (brightness),
    .alpha_in    (alpha_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .color_out   (color_out),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 15;
      2:       return 40;
      default: return 70;
    endcase
  endfunction

  // favor the extremes of a channel
  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 8'h00;
    if (roll < 30) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int n;
    forever begin
      @(posedge clk);
      n = idle_len(out_idle_pct);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic send_pixel(input logic [8:0] h, input logic [7:0] s, input logic [7:0] v,
                            input logic [7:0] a);
    int gap;
    gap = idle_len(in_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    alpha_in   <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [8:0] h;
    int         roll;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sector edges, wrapped hues, saturation/value extremes, exact halves
    send_pixel(9'd0,   8'd0,   8'd0,   8'h00);
    send_pixel(9'd0,   8'd255, 8'd255, 8'hFF);
    send_pixel(9'd59,  8'd255, 8'd255, 8'h5A);
    send_pixel(9'd60,  8'd255, 8'd255, 8'hA5);
    send_pixel(9'd119, 8'd128, 8'd200, 8'h01);
    send_pixel(9'd120, 8'd255, 8'd255, 8'h80);
    send_pixel(9'd179, 8'd77,  8'd255, 8'h7F);
    send_pixel(9'd180, 8'd255, 8'd255, 8'hFE);
    send_pixel(9'd239, 8'd255, 8'd128, 8'h00);
    send_pixel(9'd240, 8'd255, 8'd255, 8'hFF);
    send_pixel(9'd299, 8'd200, 8'd33,  8'h55);
    send_pixel(9'd300, 8'd255, 8'd255, 8'hAA);
    send_pixel(9'd359, 8'd255, 8'd255, 8'h00);
    send_pixel(9'd360, 8'd255, 8'd255, 8'h11);
    send_pixel(9'd419, 8'd255, 8'd200, 8'h22);
    send_pixel(9'd420, 8'd255, 8'd255, 8'h33);
    send_pixel(9'd479, 8'd100, 8'd100, 8'h44);
    send_pixel(9'd480, 8'd255, 8'd255, 8'h66);
    send_pixel(9'd511, 8'd255, 8'd255, 8'h77);
    send_pixel(9'd30,  8'd255, 8'd1,   8'h00);
    send_pixel(9'd90,  8'd255, 8'd1,   8'h00);
    send_pixel(9'd210, 8'd255, 8'd3,   8'h00);
    send_pixel(9'd150, 8'd0,   8'd255, 8'h99);
    send_pixel(9'd270, 8'd255, 8'd0,   8'hCC);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % PHASE_LEN == 0) begin
        in_idle_pct  = pick_pct();
        out_idle_pct = pick_pct();
      end
      roll = $urandom_range(0, 9);
      if (roll < 7)
        h = 9'($urandom_range(0, 359));
      else if (roll < 8)
        h = 9'($urandom_range(360, 511));
      else
        h = 9'(60 * $urandom_range(1, 8) - 1 + $urandom_range(0, 2));
      send_pixel(h, pick_byte(), pick_byte(), 8'($urandom_range(0, 255)));
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
